### design/ctb_pkg.sv
package ctb_pkg;

  // Store depth and the derived index and counter widths.
  localparam int MaxNodes = 1024;
  localparam int KeyBits  = 32;
  localparam int IdxW     = $clog2(MaxNodes);
  localparam int CntW     = $clog2(MaxNodes + 1);

  // One tree link: a valid flag and a node index.
  typedef struct packed {
    logic            vld;
    logic [IdxW-1:0] idx;
  } link_t;

  localparam int LinkW = $bits(link_t);

  // Result of one insert, handed from the sequencer to the output register.
  typedef struct packed {
    logic [IdxW-1:0] position;
    logic            has_parent;
    logic [IdxW-1:0] parent_index;
    logic            has_left;
    logic [IdxW-1:0] left_index;
    logic [IdxW-1:0] root_index;
    logic            overflow;
  } res_t;

endpackage

### design/ctb_ram.sv
module ctb_ram #(
  parameter int Width = 11,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/ctb_ctrl.sv
module ctb_ctrl
  import ctb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input transaction.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                start_new_i,
  input  logic [KeyBits-1:0]  value_i,
  // Shared read address and registered read data of the three stores.
  output logic [IdxW-1:0]     rd_addr_o,
  input  logic [KeyBits-1:0]  key_rd_i,
  input  link_t               par_rd_i,
  input  link_t               rgt_rd_i,
  // Write ports.
  output logic                key_we_o,
  output logic [IdxW-1:0]     key_waddr_o,
  output logic [KeyBits-1:0]  key_wdata_o,
  output logic                par_we_o,
  output logic [IdxW-1:0]     par_waddr_o,
  output link_t               par_wdata_o,
  output logic                rgt_we_o,
  output logic [IdxW-1:0]     rgt_waddr_o,
  output link_t               rgt_wdata_o,
  // Finished result toward the output register.
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output res_t                res_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_FIX  = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  logic [2:0]         state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [IdxW-1:0]    root_q, root_d;
  logic [IdxW-1:0]    node_q, node_d;
  logic [IdxW-1:0]    walk_q, walk_d;
  logic [KeyBits-1:0] key_q, key_d;
  link_t              child_q, child_d;
  res_t               res_q, res_d;

  logic               accept;
  logic [CntW-1:0]    cnt_eff;
  logic [IdxW-1:0]    new_idx;
  logic               greater;

  assign accept  = in_valid_i && (state_q == S_IDLE);
  assign cnt_eff = start_new_i ? '0 : cnt_q;
  assign new_idx = cnt_eff[IdxW-1:0];
  // The single compare unit: is the stored key strictly above the new key?
  assign greater = $signed(key_rd_i) > $signed(key_q);

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  // Sequencer: append, climb the right spine one node per cycle, relink.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    root_d      = root_q;
    node_d      = node_q;
    walk_d      = walk_q;
    key_d       = key_q;
    child_d     = child_q;
    res_d       = res_q;
    rd_addr_o   = walk_q;
    key_we_o    = 1'b0;
    key_waddr_o = new_idx;
    key_wdata_o = value_i;
    par_we_o    = 1'b0;
    par_waddr_o = new_idx;
    par_wdata_o = '0;
    rgt_we_o    = 1'b0;
    rgt_waddr_o = new_idx;
    rgt_wdata_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (start_new_i) begin
            root_d = '0;
          end
          if (cnt_eff == CntW'(MaxNodes)) begin
            // Store full: drop the value and report the current root.
            res_d            = '0;
            res_d.root_index = start_new_i ? '0 : root_q;
            res_d.overflow   = 1'b1;
            state_d          = S_DONE;
          end else begin
            // Append the node with no links yet.
            key_we_o = 1'b1;
            par_we_o = 1'b1;
            rgt_we_o = 1'b1;
            cnt_d    = cnt_eff + CntW'(1);
            node_d   = new_idx;
            key_d    = value_i;
            if (cnt_eff == '0) begin
              root_d            = '0;
              res_d             = '0;
              state_d           = S_DONE;
            end else begin
              walk_d    = new_idx - IdxW'(1);
              rd_addr_o = new_idx - IdxW'(1);
              state_d   = S_WALK;
            end
          end
        end
      end
      S_WALK: begin
        if (par_rd_i.vld && greater) begin
          // Keep climbing toward the root.
          walk_d    = par_rd_i.idx;
          rd_addr_o = par_rd_i.idx;
        end else if (greater) begin
          // Climbed past the root: the new node becomes the root.
          par_we_o           = 1'b1;
          par_waddr_o        = walk_q;
          par_wdata_o        = '{vld: 1'b1, idx: node_q};
          root_d             = node_q;
          res_d.position     = node_q;
          res_d.has_parent   = 1'b0;
          res_d.parent_index = '0;
          res_d.has_left     = 1'b1;
          res_d.left_index   = walk_q;
          res_d.root_index   = node_q;
          res_d.overflow     = 1'b0;
          state_d            = S_DONE;
        end else begin
          // Hang the new node as right child and adopt the former right child.
          rgt_we_o           = 1'b1;
          rgt_waddr_o        = walk_q;
          rgt_wdata_o        = '{vld: 1'b1, idx: node_q};
          par_we_o           = 1'b1;
          par_waddr_o        = node_q;
          par_wdata_o        = '{vld: 1'b1, idx: walk_q};
          child_d            = rgt_rd_i;
          res_d.position     = node_q;
          res_d.has_parent   = 1'b1;
          res_d.parent_index = walk_q;
          res_d.has_left     = rgt_rd_i.vld;
          res_d.left_index   = rgt_rd_i.vld ? rgt_rd_i.idx : '0;
          res_d.root_index   = root_q;
          res_d.overflow     = 1'b0;
          state_d            = rgt_rd_i.vld ? S_FIX : S_DONE;
        end
      end
      S_FIX: begin
        // The adopted child now points at the new node.
        par_we_o    = 1'b1;
        par_waddr_o = child_q.idx;
        par_wdata_o = '{vld: 1'b1, idx: node_q};
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      root_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      root_q  <= root_d;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    walk_q  <= walk_d;
    key_q   <= key_d;
    child_q <= child_d;
    res_q   <= res_d;
  end

endmodule

### design/cartesian_tree_builder_core.sv
// Incremental min-Cartesian tree builder.
//
// Input channel (in_valid_i / in_stall_o): each transaction appends value_i
// as the next node; start_new_i discards the current tree first. Output
// channel (out_valid_o / out_stall_i): one result transaction per input with
// the new node's position, its parent and adopted left child, the root, and
// an overflow flag when the store of 1024 nodes is full.
//
// One item is handled at a time. After acceptance the sequencer climbs the
// right spine one node per cycle, set by the registered read port of the
// node stores, then relinks a former right child if there is one, and hands
// the result to the output register, which drives out_valid_o. The input
// side stays stalled until the sequencer is back in its idle state, which
// also waits for the output register to take the result. Empty-tree and
// overflow items skip the climb and go straight to the done state.
//
// Reset empties the tree; the stores need no clearing. A finished result
// waits in the output register while out_stall_i is high; the next item can be
// accepted meanwhile, and its result waits until the register frees up.
module cartesian_tree_builder_core
  import ctb_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            start_new_i,
  input  logic [31:0]     value_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [IdxW-1:0] position_o,
  output logic            has_parent_o,
  output logic [IdxW-1:0] parent_index_o,
  output logic            has_left_o,
  output logic [IdxW-1:0] left_index_o,
  output logic [IdxW-1:0] root_index_o,
  output logic            overflow_o
);

  logic [IdxW-1:0]    rd_addr;
  logic [KeyBits-1:0] key_rd;
  logic [LinkW-1:0]   par_rd_raw, rgt_rd_raw;
  link_t              par_rd, rgt_rd;
  logic               key_we, par_we, rgt_we;
  logic [IdxW-1:0]    key_waddr, par_waddr, rgt_waddr;
  logic [KeyBits-1:0] key_wdata;
  link_t              par_wdata, rgt_wdata;
  logic               res_valid, res_ready;
  res_t               res;
  logic               out_valid_q;
  res_t               out_q;

  assign par_rd = link_t'(par_rd_raw);
  assign rgt_rd = link_t'(rgt_rd_raw);

  // Node stores: keys, parent links and right links.
  ctb_ram #(.Width(KeyBits), .Depth(MaxNodes)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (rd_addr),
    .rdata_o (key_rd)
  );

  ctb_ram #(.Width(LinkW), .Depth(MaxNodes)) u_par_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (par_waddr),
    .wdata_i (par_wdata),
    .raddr_i (rd_addr),
    .rdata_o (par_rd_raw)
  );

  ctb_ram #(.Width(LinkW), .Depth(MaxNodes)) u_rgt_ram (
    .clk_i   (clk_i),
    .we_i    (rgt_we),
    .waddr_i (rgt_waddr),
    .wdata_i (rgt_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rgt_rd_raw)
  );

  // Sequencer with the shared key compare.
  ctb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .start_new_i (start_new_i),
    .value_i     (value_i),
    .rd_addr_o   (rd_addr),
    .key_rd_i    (key_rd),
    .par_rd_i    (par_rd),
    .rgt_rd_i    (rgt_rd),
    .key_we_o    (key_we),
    .key_waddr_o (key_waddr),
    .key_wdata_o (key_wdata),
    .par_we_o    (par_we),
    .par_waddr_o (par_waddr),
    .par_wdata_o (par_wdata),
    .rgt_we_o    (rgt_we),
    .rgt_waddr_o (rgt_waddr),
    .rgt_wdata_o (rgt_wdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: loads when empty or when its transaction completes.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign position_o     = out_q.position;
  assign has_parent_o   = out_q.has_parent;
  assign parent_index_o = out_q.parent_index;
  assign has_left_o     = out_q.has_left;
  assign left_index_o   = out_q.left_index;
  assign root_index_o   = out_q.root_index;
  assign overflow_o     = out_q.overflow;

endmodule

### design/ctb_checker.sv
module ctb_checker
  import ctb_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic [IdxW-1:0] position_o,
  input logic            has_parent_o,
  input logic [IdxW-1:0] parent_index_o,
  input logic            has_left_o,
  input logic [IdxW-1:0] left_index_o,
  input logic [IdxW-1:0] root_index_o,
  input logic            overflow_o
);

  // A stalled result transaction stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // One item at a time: after an accepted input the block is busy.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in work");

  // A dropped value reports no node and no links.
  a_overflow_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> !has_parent_o && !has_left_o && position_o == '0)
    else $error("overflow result carries links");

  // A new node without a parent is the root.
  a_orphan_is_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !overflow_o && !has_parent_o |-> root_index_o == position_o)
    else $error("parentless node is not the root");

  // Parents and adopted children precede the new node.
  a_links_earlier: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !overflow_o |->
      (!has_parent_o || parent_index_o < position_o) &&
      (!has_left_o || left_index_o < position_o))
    else $error("link to a later node");

endmodule

bind cartesian_tree_builder_core ctb_checker u_ctb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .position_o     (position_o),
  .has_parent_o   (has_parent_o),
  .parent_index_o (parent_index_o),
  .has_left_o     (has_left_o),
  .left_index_o   (left_index_o),
  .root_index_o   (root_index_o),
  .overflow_o     (overflow_o)
);
